// ===== sv/tpi_pkg.sv =====
package tpi_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  localparam logic [12:0] LIMIT_RST = 13'd4096;
  localparam logic [15:0] LAG_RST   = 16'd17;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_POS    = 2'd1;
  localparam logic [1:0] FN_VEL    = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FEW    = 3'd1;
  localparam logic [2:0] ST_LAST   = 3'd2;
  localparam logic [2:0] ST_FIRST  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_LAG   = 1'b1;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

endpackage

// ===== sv/tpi_in_if.sv =====
interface tpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [31:0]        time_req;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  modport source (output valid, func, time_req, pos_x, pos_y, input ready);
  modport sink (input valid, func, time_req, pos_x, pos_y, output ready);
endinterface

// ===== sv/tpi_out_if.sv =====
interface tpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] out_x;
  logic signed [24:0] out_y;
  logic [2:0]         status;
  modport source (output valid, out_x, out_y, status, input ready);
  modport sink (input valid, out_x, out_y, status, output ready);
endinterface

// ===== sv/timed_path_interpolator.sv =====
// Append and clear: the store is updated at the transfer and the result goes to the output state.
// Position query when interpolating: binary search (one memory read a cycle), x and y products
// formed in turn into one product register, then a 25-step divider; velocity is two lookups.
// One item in work at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous) empties the store and restores the registers;
// point memory content is not cleared.
module timed_path_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  tpi_in_if.sink      in_ch,
  tpi_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LK0   = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_BS    = 4'd3;
  localparam logic [3:0] S_FIRST = 4'd4;
  localparam logic [3:0] S_A     = 4'd5;
  localparam logic [3:0] S_B     = 4'd6;
  localparam logic [3:0] S_MX    = 4'd7;
  localparam logic [3:0] S_MY    = 4'd8;
  localparam logic [3:0] S_DV0   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_RES   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int AW = tpi_pkg::AW;
  localparam int CW = tpi_pkg::CW;

  tpi_pkg::entry_t mem [tpi_pkg::MAX_POINTS];
  tpi_pkg::entry_t rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  tpi_pkg::entry_t wr_data;

  logic [3:0]    state_r;
  logic [12:0]   limit_r;
  logic [15:0]   lag_r;
  logic [AW-1:0] oldest_r;
  logic [CW-1:0] count_r;
  logic [31:0]   last_t_r;
  logic [1:0]    func_r;
  logic          pass_r;
  logic [31:0]   qt_r;
  logic [31:0]   tp_r;
  logic [CW-1:0] lo_r, hi_r, mid_r;
  tpi_pkg::entry_t ent_a_r;
  logic [31:0]   den_r, off_r;
  logic [16:0]   ax_r, ay_r;
  logic          nx_r, ny_r;
  logic [48:0]   prod_r;
  logic [32:0]   rem_x_r, rem_y_r;
  logic [24:0]   nl_x_r, nl_y_r, q_x_r, q_y_r;
  logic [4:0]    cnt_r;
  logic signed [24:0] lk_x_r, lk_y_r, v_x_r, v_y_r, o_x_r, o_y_r;
  logic [2:0]    lk_st_r, v_st_r, o_st_r;
  logic          out_valid_r;
  logic signed [24:0] out_x_r, out_y_r;
  logic [2:0]    out_st_r;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] l);
    slot = base + l[AW-1:0];
  endfunction

  function automatic logic signed [24:0] q8(input logic signed [15:0] v);
    q8 = {v[15], v, 8'd0};
  endfunction

  logic [12:0]   lim;
  logic          bs_gt;
  logic [CW-1:0] nlo, nhi, nmid;
  logic          in_acc, cfg_wr;
  logic [CW-1:0] drop, cnt_keep;
  logic [AW-1:0] old_new;
  logic signed [16:0] dx, dy;
  logic [32:0]   tx, ty;
  logic          gex, gey;
  logic signed [24:0] qx, qy;

  always_comb begin
    if (limit_r < 13'd2) begin
      lim = 13'd2;
    end else if (limit_r > 13'(tpi_pkg::MAX_POINTS)) begin
      lim = 13'(tpi_pkg::MAX_POINTS);
    end else begin
      lim = limit_r;
    end
  end

  assign bs_gt = rd_q.t > qt_r;
  assign nlo   = bs_gt ? lo_r : mid_r + 1'b1;
  assign nhi   = bs_gt ? mid_r : hi_r;
  assign nmid  = nlo + ((nhi - nlo) >> 1);

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {16'd0, lag_r} : {19'd0, limit_r};

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = out_x_r;
  assign out_ch.out_y  = out_y_r;
  assign out_ch.status = out_st_r;

  always_comb begin
    if (count_r >= CW'(lim)) begin
      drop     = count_r - CW'(lim) + 1'b1;
      cnt_keep = CW'(lim) - 1'b1;
    end else begin
      drop     = '0;
      cnt_keep = count_r;
    end
    old_new = oldest_r + drop[AW-1:0];
  end

  assign wr_en   = in_acc && (in_ch.func == tpi_pkg::FN_APPEND) &&
                   !(count_r != '0 && in_ch.time_req < last_t_r);
  assign wr_addr = slot(old_new, cnt_keep);
  assign wr_data = '{t: in_ch.time_req, x: in_ch.pos_x, y: in_ch.pos_y};

  always_comb begin
    case (state_r)
      S_LK0:   rd_addr = slot(oldest_r, count_r - 1'b1);
      S_LAST:  rd_addr = slot(oldest_r, (count_r - 1'b1) >> 1);
      S_BS: begin
        if (nlo < nhi) begin
          rd_addr = slot(oldest_r, nmid);
        end else if (nlo == '0) begin
          rd_addr = oldest_r;
        end else begin
          rd_addr = slot(oldest_r, nlo - 1'b1);
        end
      end
      S_A:     rd_addr = slot(oldest_r, lo_r);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign dx  = 17'(rd_q.x) - 17'(ent_a_r.x);
  assign dy  = 17'(rd_q.y) - 17'(ent_a_r.y);
  assign tx  = {rem_x_r[31:0], nl_x_r[24]};
  assign ty  = {rem_y_r[31:0], nl_y_r[24]};
  assign gex = tx >= {1'b0, den_r};
  assign gey = ty >= {1'b0, den_r};
  assign qx  = nx_r ? -$signed(q_x_r) - 25'(rem_x_r != '0) : $signed(q_x_r);
  assign qy  = ny_r ? -$signed(q_y_r) - 25'(rem_y_r != '0) : $signed(q_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= tpi_pkg::LIMIT_RST;
      lag_r       <= tpi_pkg::LAG_RST;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == tpi_pkg::REG_LIMIT) begin
          limit_r <= cfg_pwdata[12:0];
        end else begin
          lag_r <= cfg_pwdata[15:0];
        end
      end
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_ch.func;
            pass_r <= 1'b0;
            qt_r   <= in_ch.time_req;
            tp_r   <= (in_ch.time_req >= 32'(lag_r)) ? in_ch.time_req - 32'(lag_r) : '0;
            o_x_r  <= '0;
            o_y_r  <= '0;
            o_st_r <= tpi_pkg::ST_OK;
            case (in_ch.func)
              tpi_pkg::FN_APPEND: begin
                if (wr_en) begin
                  oldest_r <= old_new;
                  count_r  <= cnt_keep + 1'b1;
                  last_t_r <= in_ch.time_req;
                end else begin
                  o_st_r <= tpi_pkg::ST_REJECT;
                end
                state_r <= S_OUT;
              end
              tpi_pkg::FN_CLEAR: begin
                oldest_r <= '0;
                count_r  <= '0;
                state_r  <= S_OUT;
              end
              default: state_r <= S_LK0;
            endcase
          end
        end
        S_LK0: begin
          if (count_r < CW'(2)) begin
            lk_x_r  <= '0;
            lk_y_r  <= '0;
            lk_st_r <= tpi_pkg::ST_FEW;
            state_r <= S_FIN;
          end else begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          if (qt_r >= rd_q.t) begin
            lk_x_r  <= q8(rd_q.x);
            lk_y_r  <= q8(rd_q.y);
            lk_st_r <= tpi_pkg::ST_LAST;
            state_r <= S_FIN;
          end else begin
            lo_r    <= '0;
            hi_r    <= count_r - 1'b1;
            mid_r   <= (count_r - 1'b1) >> 1;
            state_r <= S_BS;
          end
        end
        S_BS: begin
          lo_r  <= nlo;
          hi_r  <= nhi;
          mid_r <= nmid;
          if (nlo >= nhi) begin
            state_r <= (nlo == '0) ? S_FIRST : S_A;
          end
        end
        S_FIRST: begin
          lk_x_r  <= q8(rd_q.x);
          lk_y_r  <= q8(rd_q.y);
          lk_st_r <= tpi_pkg::ST_FIRST;
          state_r <= S_FIN;
        end
        S_A: begin
          ent_a_r <= rd_q;
          state_r <= S_B;
        end
        S_B: begin
          den_r   <= (rd_q.t == ent_a_r.t) ? 32'd1 : rd_q.t - ent_a_r.t;
          off_r   <= qt_r - ent_a_r.t;
          ax_r    <= dx[16] ? 17'(-dx) : 17'(dx);
          ay_r    <= dy[16] ? 17'(-dy) : 17'(dy);
          nx_r    <= dx[16];
          ny_r    <= dy[16];
          state_r <= S_MX;
        end
        S_MX: begin
          prod_r  <= ax_r * off_r;
          state_r <= S_MY;
        end
        S_MY: begin
          rem_x_r <= {1'b0, prod_r[48:17]};
          nl_x_r  <= {prod_r[16:0], 8'd0};
          prod_r  <= ay_r * off_r;
          state_r <= S_DV0;
        end
        S_DV0: begin
          rem_y_r <= {1'b0, prod_r[48:17]};
          nl_y_r  <= {prod_r[16:0], 8'd0};
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_x_r <= gex ? tx - {1'b0, den_r} : tx;
          rem_y_r <= gey ? ty - {1'b0, den_r} : ty;
          q_x_r   <= {q_x_r[23:0], gex};
          q_y_r   <= {q_y_r[23:0], gey};
          nl_x_r  <= {nl_x_r[23:0], 1'b0};
          nl_y_r  <= {nl_y_r[23:0], 1'b0};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == 5'd24) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          lk_x_r  <= q8(ent_a_r.x) + qx;
          lk_y_r  <= q8(ent_a_r.y) + qy;
          lk_st_r <= tpi_pkg::ST_OK;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (func_r == tpi_pkg::FN_VEL && !pass_r) begin
            v_x_r   <= lk_x_r;
            v_y_r   <= lk_y_r;
            v_st_r  <= lk_st_r;
            pass_r  <= 1'b1;
            qt_r    <= tp_r;
            state_r <= S_LK0;
          end else if (func_r == tpi_pkg::FN_VEL) begin
            o_x_r   <= v_x_r - lk_x_r;
            o_y_r   <= v_y_r - lk_y_r;
            o_st_r  <= v_st_r;
            state_r <= S_OUT;
          end else begin
            o_x_r   <= lk_x_r;
            o_y_r   <= lk_y_r;
            o_st_r  <= lk_st_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_x_r     <= o_x_r;
            out_y_r     <= o_y_r;
            out_st_r    <= o_st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
